@@ hw/rtl/se2er_pkg.sv @@
// shared types, constants and the cordic arctangent table for the edge residual block
package se2er_pkg;

  localparam int CordicSteps = 16;
  localparam int CfgIdxW = 3;

  localparam logic signed [16:0] HalfPiQ13 = 17'sd12868;
  localparam logic signed [16:0] PiQ13 = 17'sd25736;
  localparam logic signed [18:0] PiQ13W = 19'sd25736;
  localparam logic signed [18:0] TwoPiQ13 = 19'sd51472;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  localparam logic [CfgIdxW-1:0] RegW00 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegW10 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegW11 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegW20 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegW21 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegW22 = 3'd5;

  typedef struct packed {
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [15:0] from_heading;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    logic signed [15:0] to_heading;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [15:0] meas_heading;
  } edge_in_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_heading;
  } edge_out_t;

  // state handed from cell to cell
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               neg;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [21:0] eh;
  } cord_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/se2er_cell.sv @@
// one cordic rotation cell with its sideband, registered
module se2er_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [4:0]           step,
  input  logic                 vin,
  input  se2er_pkg::cord_t     din,
  output logic                 vout,
  output se2er_pkg::cord_t     dout
);
  import se2er_pkg::*;

  cord_t nxt;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;

  always_comb begin
    xs = din.x >>> step;
    ys = din.y >>> step;
    at = atan_q30(step);
    nxt = din;
    if (!din.z[33]) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - at;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

@@ hw/rtl/se2_edge_residual_top.sv @@
// edge residual top: front stage, cordic cell chain, rotation and weighting stages
// stages in order: front, cordic cells, sign fix, products, error, weights, output
// throughput: one item per cycle; the whole pipe holds only when the result waits
// the chain of cordic cells does one rotation per cell
// reset: synchronous rst clears all valid bits and loads the weights with identity
module se2_edge_residual_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  se2er_pkg::edge_in_t             in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output se2er_pkg::edge_out_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [se2er_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import se2er_pkg::*;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  // weights
  logic signed [31:0] w00, w10, w11, w20, w21, w22;
  always_ff @(posedge clk) begin
    if (rst) begin
      w00 <= 32'sd65536;
      w10 <= 32'sd0;
      w11 <= 32'sd65536;
      w20 <= 32'sd0;
      w21 <= 32'sd0;
      w22 <= 32'sd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegW00:  w00 <= {1'b0, cfg_data[30:0]};
        RegW10:  w10 <= cfg_data;
        RegW11:  w11 <= {1'b0, cfg_data[30:0]};
        RegW20:  w20 <= cfg_data;
        RegW21:  w21 <= cfg_data;
        RegW22:  w22 <= {1'b0, cfg_data[30:0]};
        default: ;
      endcase
    end
  end

  // front stage: quadrant fold, differences, heading error wrap
  cord_t front;
  logic signed [16:0] h;
  logic signed [18:0] dt;
  always_comb begin
    front = '0;
    h = 17'(in_data.from_heading);
    front.neg = 1'b0;
    if (h > HalfPiQ13) begin
      h = h - PiQ13;
      front.neg = 1'b1;
    end else if (h < -HalfPiQ13) begin
      h = h + PiQ13;
      front.neg = 1'b1;
    end
    front.x = CordicGain;
    front.y = 34'sd0;
    front.z = 34'(h) <<< 17;
    front.dx = 33'(in_data.to_x) - 33'(in_data.from_x);
    front.dy = 33'(in_data.to_y) - 33'(in_data.from_y);
    front.mx = in_data.meas_x;
    front.my = in_data.meas_y;
    dt = 19'(in_data.meas_heading) - (19'(in_data.to_heading) - 19'(in_data.from_heading));
    if (dt > PiQ13W) dt = dt - TwoPiQ13;
    if (dt > PiQ13W) dt = dt - TwoPiQ13;
    if (dt <= -PiQ13W) dt = dt + TwoPiQ13;
    if (dt <= -PiQ13W) dt = dt + TwoPiQ13;
    front.eh = 22'(dt) <<< 3;
  end

  logic  cv [CordicSteps+1];
  cord_t cd [CordicSteps+1];
  logic  v0;
  cord_t d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d0 <= front;
    end
  end

  assign cv[0] = v0;
  assign cd[0] = d0;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    se2er_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .step (5'(g)),
      .vin  (cv[g]),
      .din  (cd[g]),
      .vout (cv[g+1]),
      .dout (cd[g+1])
    );
  end

  // sign fix of sin and cos
  logic               v1;
  logic signed [33:0] c1, s1;
  logic signed [32:0] dx1, dy1;
  logic signed [31:0] mx1, my1;
  logic signed [21:0] eh1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= cv[CordicSteps];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= cd[CordicSteps].neg ? -cd[CordicSteps].x : cd[CordicSteps].x;
      s1 <= cd[CordicSteps].neg ? -cd[CordicSteps].y : cd[CordicSteps].y;
      dx1 <= cd[CordicSteps].dx;
      dy1 <= cd[CordicSteps].dy;
      mx1 <= cd[CordicSteps].mx;
      my1 <= cd[CordicSteps].my;
      eh1 <= cd[CordicSteps].eh;
    end
  end

  // rotation partial products, differences split into high and low halves
  logic               v2;
  logic signed [50:0] cxh, cxl, syh, syl, cyh, cyl, sxh, sxl;
  logic signed [31:0] mx2, my2;
  logic signed [21:0] eh2;
  logic signed [16:0] dxh, dxl, dyh, dyl;
  assign dxh = dx1[32:16];
  assign dxl = {1'b0, dx1[15:0]};
  assign dyh = dy1[32:16];
  assign dyl = {1'b0, dy1[15:0]};
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cxh <= 51'(c1 * dxh);
      cxl <= 51'(c1 * dxl);
      syh <= 51'(s1 * dyh);
      syl <= 51'(s1 * dyl);
      cyh <= 51'(c1 * dyh);
      cyl <= 51'(c1 * dyl);
      sxh <= 51'(s1 * dxh);
      sxl <= 51'(s1 * dxl);
      mx2 <= mx1;
      my2 <= my1;
      eh2 <= eh1;
    end
  end

  // recombine, floor by 30, error and saturate
  logic signed [67:0] pcx, psy, pcy, psx, ex_w, ey_w;
  logic signed [31:0] ex_s, ey_s;
  always_comb begin
    pcx = ((68'(cxh) <<< 16) + 68'(cxl)) >>> 30;
    psy = ((68'(syh) <<< 16) + 68'(syl)) >>> 30;
    pcy = ((68'(cyh) <<< 16) + 68'(cyl)) >>> 30;
    psx = ((68'(sxh) <<< 16) + 68'(sxl)) >>> 30;
    ex_w = 68'(mx2) - (pcx + psy);
    ey_w = 68'(my2) - (pcy - psx);
    if (ex_w > 68'sh7FFFFFFF) ex_s = 32'sh7FFFFFFF;
    else if (ex_w < -68'sh80000000) ex_s = 32'sh80000000;
    else ex_s = ex_w[31:0];
    if (ey_w > 68'sh7FFFFFFF) ey_s = 32'sh7FFFFFFF;
    else if (ey_w < -68'sh80000000) ey_s = 32'sh80000000;
    else ey_s = ey_w[31:0];
  end

  logic               v3;
  logic signed [31:0] ex3, ey3, eh3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ex3 <= ex_s;
      ey3 <= ey_s;
      eh3 <= 32'(eh2);
    end
  end

  // weight products
  logic               v4;
  logic signed [63:0] p00, p10, p11, p20, p21, p22;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= w00 * ex3;
      p10 <= w10 * ex3;
      p11 <= w11 * ey3;
      p20 <= w20 * ex3;
      p21 <= w21 * ey3;
      p22 <= w22 * eh3;
    end
  end

  // floor by 16, sum and saturate into the output register
  logic signed [49:0] r0w, r1w, r2w;
  edge_out_t res;
  always_comb begin
    r0w = 50'(p00 >>> 16);
    r1w = 50'(p10 >>> 16) + 50'(p11 >>> 16);
    r2w = 50'(p20 >>> 16) + 50'(p21 >>> 16) + 50'(p22 >>> 16);
    if (r0w > 50'sh7FFFFFFF) res.res_x = 32'sh7FFFFFFF;
    else if (r0w < -50'sh80000000) res.res_x = 32'sh80000000;
    else res.res_x = r0w[31:0];
    if (r1w > 50'sh7FFFFFFF) res.res_y = 32'sh7FFFFFFF;
    else if (r1w < -50'sh80000000) res.res_y = 32'sh80000000;
    else res.res_y = r1w[31:0];
    if (r2w > 50'sh7FFFFFFF) res.res_heading = 32'sh7FFFFFFF;
    else if (r2w < -50'sh80000000) res.res_heading = 32'sh80000000;
    else res.res_heading = r2w[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

endmodule
